// File: src/assert_macros.svh
// Shared assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a consequence holds at any edge where the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: src/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

    // Build limit on the payload length.
    localparam logic [15:0] MAX_PAYLOAD = 16'd512;

    // Parse phases.
    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_LENH  = 3'd2;
    localparam logic [2:0] PH_LENL  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0]  SYNC_FIRST_RST    = 8'h94;
    localparam logic [7:0]  SYNC_SECOND_RST   = 8'hC3;
    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd512;

    // Output queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] payload_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        frame_done;
        logic [15:0] frame_length;
        logic        last_in_run;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } t_result;

    // Results produced by one accepted byte: cnt is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_emit;

endpackage

// File: src/sync_length_deframer.sv
`timescale 1ns / 1ps

// Two-byte sync, length-prefixed serial deframer.
// Slave stream (s_axis_*): one received serial byte per transaction in tdata[7:0].
// Master stream (m_axis_*): result transactions; tuser carries the kind (text,
// payload, length error), tlast marks the last result caused by one input byte.
// Sync and valid length bytes give no result; a broken sync pair produces two.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high (0 first sync byte, 1 second sync byte, 2 payload limit); write only
// while the block is idle.
// Results are written into the result queue as their byte is accepted and are
// presented from its registers; the second result of a pair follows the first.
// Throughput: one byte per cycle while the queue has room for a pair of results.
// A four-entry result queue decouples the two sides; s_axis_tready drops
// when fewer than two entries are free, so a stalled receiver stalls input
// once three or four results are queued. Nothing is dropped.
// Reset (synchronous, active low) returns the parser to sync hunting, clears
// the frame counters, empties the queue and restores the register defaults.
module sync_length_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [7:0] data, [8] frame_done,
                                        // [24:9] frame_length,
                                        // [56:25] good_frames,
                                        // [88:57] bad_frames, [95:89] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_in_run
);

    sld_pkg::t_cfg    r_cfg;
    sld_pkg::t_emit   emit;
    sld_pkg::t_result res;
    logic             room;
    logic             in_accept;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= sld_pkg::SYNC_FIRST_RST;
            r_cfg.sync_second   <= sld_pkg::SYNC_SECOND_RST;
            r_cfg.payload_limit <= sld_pkg::PAYLOAD_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sld_pkg::CFG_SYNC_FIRST:    r_cfg.sync_first    <= i_cfg_data[7:0];
                sld_pkg::CFG_SYNC_SECOND:   r_cfg.sync_second   <= i_cfg_data[7:0];
                sld_pkg::CFG_PAYLOAD_LIMIT: r_cfg.payload_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a byte whenever the queue can absorb a full pair of results.
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    sld_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (in_accept),
        .i_byte  (s_axis_tdata),
        .o_emit  (emit)
    );

    sld_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tdata = {7'd0, res.bad_frames, res.good_frames, res.frame_length,
                           res.frame_done, res.data};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last_in_run;

endmodule

// File: src/sld_parser.sv
`timescale 1ns / 1ps

module sld_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sld_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output sld_pkg::t_emit o_emit
);

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_exp_len, n_exp_len;
    logic [15:0] r_rcv_cnt, n_rcv_cnt;
    logic [31:0] r_good, n_good;
    logic [31:0] r_bad, n_bad;
    logic [15:0] len;
    logic [15:0] rcv_inc;
    logic        done;
    sld_pkg::t_emit emit;

    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_rcv_cnt = r_rcv_cnt;
        n_good    = r_good;
        n_bad     = r_bad;
        len       = {r_exp_len[15:8], i_byte};
        rcv_inc   = r_rcv_cnt + 16'd1;
        done      = (rcv_inc == r_exp_len);
        emit      = '0;

        unique case (r_phase)
            sld_pkg::PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    n_phase = sld_pkg::PH_LENH;
                end else begin
                    // Broken pair: release the held sync byte, then this one.
                    n_phase                 = sld_pkg::PH_SYNC1;
                    emit.cnt                = 2'd2;
                    emit.res0.kind          = sld_pkg::KIND_TEXT;
                    emit.res0.data          = i_cfg.sync_first;
                    emit.res1.kind          = sld_pkg::KIND_TEXT;
                    emit.res1.data          = i_byte;
                    emit.res1.last_in_run   = 1'b1;
                end
            end
            sld_pkg::PH_LENH: begin
                n_exp_len = {i_byte, 8'h00};
                n_phase   = sld_pkg::PH_LENL;
            end
            sld_pkg::PH_LENL: begin
                n_rcv_cnt = '0;
                if (len == 16'd0 || len > sld_pkg::MAX_PAYLOAD ||
                    len > i_cfg.payload_limit) begin
                    n_bad                   = r_bad + 32'd1;
                    n_phase                 = sld_pkg::PH_SYNC1;
                    n_exp_len               = '0;
                    emit.cnt                = 2'd1;
                    emit.res0.kind          = sld_pkg::KIND_ERROR;
                    emit.res0.frame_length  = len;
                    emit.res0.last_in_run   = 1'b1;
                end else begin
                    n_exp_len = len;
                    n_phase   = sld_pkg::PH_DATA;
                end
            end
            sld_pkg::PH_DATA: begin
                n_rcv_cnt = rcv_inc;
                if (done) begin
                    n_good  = r_good + 32'd1;
                    n_phase = sld_pkg::PH_SYNC1;
                end
                emit.cnt                = 2'd1;
                emit.res0.kind          = sld_pkg::KIND_PAYLOAD;
                emit.res0.data          = i_byte;
                emit.res0.frame_done    = done;
                emit.res0.frame_length  = r_exp_len;
                emit.res0.last_in_run   = 1'b1;
            end
            default: begin
                if (i_byte == i_cfg.sync_first) begin
                    n_phase = sld_pkg::PH_SYNC2;
                end else begin
                    n_phase               = sld_pkg::PH_SYNC1;
                    emit.cnt              = 2'd1;
                    emit.res0.kind        = sld_pkg::KIND_TEXT;
                    emit.res0.data        = i_byte;
                    emit.res0.last_in_run = 1'b1;
                end
            end
        endcase

        emit.res0.good_frames = n_good;
        emit.res0.bad_frames  = n_bad;
        emit.res1.good_frames = n_good;
        emit.res1.bad_frames  = n_bad;
        if (!i_valid) begin
            emit.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sld_pkg::PH_SYNC1;
            r_exp_len <= '0;
            r_rcv_cnt <= '0;
            r_good    <= '0;
            r_bad     <= '0;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_rcv_cnt <= n_rcv_cnt;
            r_good    <= n_good;
            r_bad     <= n_bad;
        end
    end

    assign o_emit = emit;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_phase_reachable, i_clk, i_rst_n, r_phase <= sld_pkg::PH_DATA)
    `ASSERT_IMPLIES(a_count_in_frame, i_clk, i_rst_n, r_phase == sld_pkg::PH_DATA, r_rcv_cnt < r_exp_len)
    `ASSERT_IMPLIES(a_pair_only_broken_sync, i_clk, i_rst_n, emit.cnt == 2'd2, r_phase == sld_pkg::PH_SYNC2 && i_valid)

endmodule

// File: src/sld_fifo.sv
`timescale 1ns / 1ps

module sld_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sld_pkg::t_emit    i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output sld_pkg::t_result  o_result
);

    sld_pkg::t_result r_mem [sld_pkg::FIFO_DEPTH];
    logic [sld_pkg::PTR_W-1:0] r_wr_ptr;
    logic [sld_pkg::PTR_W-1:0] r_rd_ptr;
    logic [sld_pkg::CNT_W-1:0] r_count;
    logic [sld_pkg::PTR_W-1:0] wr_ptr1;
    logic                      pop;

    assign wr_ptr1 = r_wr_ptr + sld_pkg::PTR_W'(1);
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    // Keep space for a full pair of results.
    assign o_room  = (r_count <= sld_pkg::CNT_W'(sld_pkg::FIFO_DEPTH - 2));
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_emit.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.res0;
        end
        if (i_emit.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_emit.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + sld_pkg::PTR_W'(i_emit.cnt);
            r_rd_ptr <= r_rd_ptr + sld_pkg::PTR_W'(pop);
            r_count  <= r_count + sld_pkg::CNT_W'(i_emit.cnt) - sld_pkg::CNT_W'(pop);
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= sld_pkg::CNT_W'(sld_pkg::FIFO_DEPTH))
    `ASSERT_IMPLIES(a_push_has_room, i_clk, i_rst_n, i_emit.cnt != 2'd0, o_room)
    `ASSERT_IMPLIES(a_ptr_gap, i_clk, i_rst_n, r_count != sld_pkg::CNT_W'(sld_pkg::FIFO_DEPTH),
                    r_wr_ptr - r_rd_ptr == sld_pkg::PTR_W'(r_count))

endmodule
